/* rtl/core/ccfc_pkg.sv */
package ccfc_pkg;

   localparam int MAX_DEVICES_DEF = 16;

   localparam int BYTE_W       = 8;
   localparam int CRC_W        = 16;
   localparam int POLY_W       = 15;
   localparam int POS_W        = 3;
   localparam int GROUP_W      = 2;
   localparam int DEV_IDX_W    = 4;
   localparam int CELL_IDX_W   = 4;
   localparam int CNT_CFG_W    = 5;
   localparam int CSR_IDX_W    = 1;
   localparam int REQ_USER_W   = 3;
   localparam int RSP_DATA_W   = 32;
   localparam int RSP_USER_W   = 1;

   localparam logic [CRC_W-1:0]     CRC_SEED        = 16'd16;
   localparam logic [POLY_W-1:0]    POLY_RESET      = 15'h4599;
   localparam logic [CNT_CFG_W-1:0] DEV_COUNT_RESET = 5'd1;
   localparam logic [POS_W-1:0]     DATA_BYTES      = 3'd6;
   localparam logic [POS_W-1:0]     PEC_LOW_POS     = 3'd7;
   localparam int                   CELLS_PER_GROUP = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DEVICE_COUNT = 1'b0,
      REG_CRC_POLY     = 1'b1
   } reg_index_type;

   typedef enum logic [RSP_USER_W-1:0] {
      KIND_CELL  = 1'b0,
      KIND_CHECK = 1'b1
   } result_kind_type;

   typedef struct packed {
      logic [5:0]            pad;
      logic                  read_error;
      logic                  pec_ok;
      logic [15:0]           cell_code;
      logic [CELL_IDX_W-1:0] cell_index;
      logic [DEV_IDX_W-1:0]  device_index;
   } rsp_data_type;

   // crc15 byte table entry for one address
   function automatic logic [CRC_W-1:0] crc_entry(
      input logic [BYTE_W-1:0] addr,
      input logic [POLY_W-1:0] poly
   );
      logic [CRC_W-1:0] r;
      logic             top;
      r = {1'b0, addr, 7'd0};
      for (int b = 0; b < BYTE_W; b++) begin
         top = r[14];
         r = {r[CRC_W-2:0], 1'b0};
         if (top) begin
            r = r ^ {1'b0, poly};
         end
      end
      return r;
   endfunction

endpackage

/* rtl/core/chain_cell_frame_checker_core.sv */
// channel | direction | handshake            | payload
// req     | in        | req_tvalid/tready    | tdata rx_byte, tuser first_of_read,group
// rsp     | out       | rsp_tvalid/tready    | tdata cell/check fields, tuser kind, tlast
// csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// one byte per cycle while ready; crc update and result are formed in the accepting cycle
// results appear in the cycle after the byte, held in an output register
// req_tready stays high while the output register is empty or being drained
// reset clears counters, seeds the crc with 16 and restores register defaults
// csr writes are taken every cycle
module chain_cell_frame_checker_core #(
   parameter int MAX_DEVICES = ccfc_pkg::MAX_DEVICES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ccfc_pkg::BYTE_W-1:0]         req_tdata,   // rx_byte
   input  logic [ccfc_pkg::REQ_USER_W-1:0]     req_tuser,   // first_of_read, register_group
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ccfc_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // device_index, cell_index,
                                                            // cell_code, pec_ok, read_error
   output logic [ccfc_pkg::RSP_USER_W-1:0]     rsp_tuser,   // result_kind
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ccfc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ccfc_pkg::POLY_W-1:0]         csr_data
);

   localparam int MAX_EFF = (MAX_DEVICES < 31) ? MAX_DEVICES : 31;
   localparam int CNT_W   = (MAX_EFF > 1) ? $clog2(MAX_EFF) : 1;

   logic [ccfc_pkg::CNT_CFG_W-1:0] dev_count_ff;
   logic [ccfc_pkg::POLY_W-1:0]    poly_ff;

   logic [ccfc_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic [CNT_W-1:0]               dev_ff, dev_in;
   logic [ccfc_pkg::CRC_W-1:0]     crc_ff, crc_in;
   logic [ccfc_pkg::BYTE_W-1:0]    held_ff, held_in;
   logic [ccfc_pkg::GROUP_W-1:0]   grp_ff, grp_in;
   logic                           sticky_ff, sticky_in;

   logic                           rsp_valid_ff;
   ccfc_pkg::rsp_data_type         rsp_data_ff, rsp_data_in;
   ccfc_pkg::result_kind_type      rsp_kind_ff, rsp_kind_in;
   logic                           rsp_last_ff, rsp_last_in;
   logic                           emit_in;

   logic                           accept;
   logic                           start;
   logic [ccfc_pkg::BYTE_W-1:0]    rx_byte;
   logic [ccfc_pkg::POS_W-1:0]     pos_cur;
   logic [CNT_W-1:0]               dev_cur;
   logic [ccfc_pkg::CRC_W-1:0]     crc_cur, crc_upd;
   logic [ccfc_pkg::GROUP_W-1:0]   grp_cur;
   logic                           sticky_cur;
   logic [ccfc_pkg::CNT_CFG_W-1:0] eff_count;
   logic                           is_last;
   logic                           pec_ok;
   logic [ccfc_pkg::CRC_W-1:0]     received;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign start      = req_tuser[0];
   assign rx_byte    = req_tdata;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      if (dev_count_ff == '0) begin
         eff_count = ccfc_pkg::CNT_CFG_W'(1);
      end else if (32'(dev_count_ff) > MAX_DEVICES) begin
         eff_count = ccfc_pkg::CNT_CFG_W'(MAX_DEVICES);
      end else begin
         eff_count = dev_count_ff;
      end
   end

   always_comb begin
      pos_cur    = start ? '0 : pos_ff;
      dev_cur    = start ? '0 : dev_ff;
      crc_cur    = start ? ccfc_pkg::CRC_SEED : crc_ff;
      grp_cur    = start ? req_tuser[2:1] : grp_ff;
      sticky_cur = start ? 1'b0 : sticky_ff;

      if (pos_cur < ccfc_pkg::DATA_BYTES) begin
         crc_upd = {crc_cur[7:0], 8'd0}
                 ^ ccfc_pkg::crc_entry(crc_cur[14:7] ^ rx_byte, poly_ff);
      end else begin
         crc_upd = crc_cur;
      end

      received = {held_ff, rx_byte};
      pec_ok   = (received == {crc_upd[14:0], 1'b0});
      is_last  = (6'(dev_cur) + 6'd1) >= 6'(eff_count);
   end

   always_comb begin
      pos_in      = pos_cur + 3'd1;
      dev_in      = dev_cur;
      crc_in      = crc_upd;
      held_in     = rx_byte;
      grp_in      = grp_cur;
      sticky_in   = sticky_cur;
      emit_in     = 1'b0;
      rsp_kind_in = ccfc_pkg::KIND_CELL;
      rsp_last_in = 1'b0;
      rsp_data_in = '0;
      rsp_data_in.device_index = ccfc_pkg::DEV_IDX_W'(dev_cur);

      if (pos_cur == ccfc_pkg::PEC_LOW_POS) begin
         sticky_in   = sticky_cur | !pec_ok;
         emit_in     = 1'b1;
         rsp_kind_in = ccfc_pkg::KIND_CHECK;
         rsp_last_in = is_last;
         rsp_data_in.pec_ok     = pec_ok;
         rsp_data_in.read_error = sticky_cur | !pec_ok;
         dev_in      = is_last ? '0 : dev_cur + CNT_W'(1);
         pos_in      = '0;
         crc_in      = ccfc_pkg::CRC_SEED;
      end else if (pos_cur[0] && pos_cur < ccfc_pkg::DATA_BYTES) begin
         emit_in = 1'b1;
         rsp_data_in.cell_index = ccfc_pkg::CELL_IDX_W'(pos_cur[2:1])
            + ccfc_pkg::CELL_IDX_W'(ccfc_pkg::CELLS_PER_GROUP) * ccfc_pkg::CELL_IDX_W'(grp_cur);
         rsp_data_in.cell_code  = {rx_byte, held_ff};
         rsp_data_in.read_error = sticky_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_count_ff <= ccfc_pkg::DEV_COUNT_RESET;
         poly_ff      <= ccfc_pkg::POLY_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ccfc_pkg::REG_DEVICE_COUNT: dev_count_ff <= csr_data[ccfc_pkg::CNT_CFG_W-1:0];
            ccfc_pkg::REG_CRC_POLY:     poly_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         dev_ff    <= '0;
         crc_ff    <= ccfc_pkg::CRC_SEED;
         held_ff   <= '0;
         grp_ff    <= '0;
         sticky_ff <= 1'b0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         dev_ff    <= dev_in;
         crc_ff    <= crc_in;
         held_ff   <= held_in;
         grp_ff    <= grp_in;
         sticky_ff <= sticky_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= emit_in;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit_in) begin
         rsp_data_ff <= rsp_data_in;
         rsp_kind_ff <= rsp_kind_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

endmodule
